### rtl/frustum_cull_test_top_defines.svh
// assertion macros for the frustum culling block
`ifndef FRUSTUM_CULL_TEST_TOP_DEFINES_SVH
`define FRUSTUM_CULL_TEST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frustum cull assertion failed");
`define FCT_ASSERT_NEXT(lbl, clk, rst_n, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("frustum cull sequencing failed");
`else
`define FCT_ASSERT(lbl, clk, rst_n, prop)
`define FCT_ASSERT_NEXT(lbl, clk, rst_n, cond, res)
`endif
`endif

### rtl/fct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_pkg
// types and constants shared by the frustum culling block
// ----------------------------------------------------------------------------
package fct_pkg;
    localparam int NUM_PLANES = 6;
    localparam int CORNERS    = 8;
    localparam int DIST_W     = 67;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_POINT  = 2'd1,
        ACT_SPHERE = 2'd2,
        ACT_BOX    = 2'd3
    } t_action;

    localparam logic [1:0] VERD_OUTSIDE   = 2'd0;
    localparam logic [1:0] VERD_INTERSECT = 2'd1;
    localparam logic [1:0] VERD_INSIDE    = 2'd2;

    typedef logic signed [DIST_W-1:0] t_dist;
endpackage

### rtl/fct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_in_if / fct_out_if
// valid/ready channels for test items and verdicts
// ----------------------------------------------------------------------------
interface fct_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [2:0]         plane_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] w_value;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    modport source (output valid, action, plane_index, coord_x, coord_y, coord_z,
                    w_value, box_max_x, box_max_y, box_max_z, input ready);
    modport sink   (input valid, action, plane_index, coord_x, coord_y, coord_z,
                    w_value, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface fct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

### rtl/frustum_cull_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_test_top
// six-plane view frustum test for points, spheres and boxes in Q16.16
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one transaction per item: a plane load (action 0) writes
//   plane a,b,c,d into the table at once and gives no verdict; a point,
//   sphere or box test gives one verdict on o_out.
//   tests see every load accepted before them.
//   throughput: one item per cycle; the four stages are products of
//   coefficients and coordinates, corner distance sums, per-plane compares,
//   and the verdict reduction in the output register.
//   when o_out is stalled the whole pipeline holds and i_in.ready drops,
//   so nothing is lost or repeated; a stage holding no item still frees
//   the pipeline only through the output register.
//   reset: the plane table clears to zero and all stages empty.
// ----------------------------------------------------------------------------
`include "frustum_cull_test_top_defines.svh"

module frustum_cull_test_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fct_in_if.sink    i_in,
    fct_out_if.source o_out
);
    localparam int NP  = fct_pkg::NUM_PLANES;
    localparam int NC  = fct_pkg::CORNERS;
    localparam int DW  = fct_pkg::DIST_W;
    localparam int PIW = (NP > 1) ? $clog2(NP) : 1;

    logic signed [31:0] r_pa [NP];
    logic signed [31:0] r_pb [NP];
    logic signed [31:0] r_pc [NP];
    logic signed [31:0] r_pd [NP];

    logic w_adv, w_acc;
    assign w_adv = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;
    assign w_acc = i_in.valid && w_adv;

    // stage 1: products
    logic               r_v1;
    logic [1:0]         r_act1;
    logic signed [63:0] r_ax [NP][2];
    logic signed [63:0] r_by [NP][2];
    logic signed [63:0] r_cz [NP][2];
    logic signed [47:0] r_d1 [NP];
    logic signed [47:0] r_r1;

    // stage 2: distances
    logic               r_v2;
    logic [1:0]         r_act2;
    fct_pkg::t_dist     r_t [NP][NC];
    fct_pkg::t_dist     r_r2, r_nr2;
    fct_pkg::t_dist     n_t [NP][NC];
    fct_pkg::t_dist     n_r2;

    // stage 3: compare flags
    logic               r_v3;
    logic [1:0]         r_act3;
    logic [NC-1:0]      r_beh  [NP];
    logic [NP-1:0]      r_pos, r_sout, r_scr;

    // stage 4: output
    logic               r_v4;
    logic [1:0]         r_verdict;
    logic [1:0]         n_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++) begin
                r_pa[p] <= '0;
                r_pb[p] <= '0;
                r_pc[p] <= '0;
                r_pd[p] <= '0;
            end
        end else if (w_acc && i_in.action == fct_pkg::ACT_LOAD
                     && 32'(i_in.plane_index) < NP) begin
            r_pa[i_in.plane_index[PIW-1:0]] <= i_in.coord_x;
            r_pb[i_in.plane_index[PIW-1:0]] <= i_in.coord_y;
            r_pc[i_in.plane_index[PIW-1:0]] <= i_in.coord_z;
            r_pd[i_in.plane_index[PIW-1:0]] <= i_in.w_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_acc && i_in.action != fct_pkg::ACT_LOAD;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // products use the table as it stands before this edge's load
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_act1 <= i_in.action;
            r_r1   <= {i_in.w_value, 16'h0000};
            for (int p = 0; p < NP; p++) begin
                r_ax[p][0] <= r_pa[p] * i_in.coord_x;
                r_ax[p][1] <= r_pa[p] * i_in.box_max_x;
                r_by[p][0] <= r_pb[p] * i_in.coord_y;
                r_by[p][1] <= r_pb[p] * i_in.box_max_y;
                r_cz[p][0] <= r_pc[p] * i_in.coord_z;
                r_cz[p][1] <= r_pc[p] * i_in.box_max_z;
                r_d1[p]    <= {r_pd[p], 16'h0000};
            end
        end
    end

    always_comb begin
        n_r2 = DW'(r_r1);
        for (int p = 0; p < NP; p++) begin
            for (int c = 0; c < NC; c++) begin
                n_t[p][c] = DW'(r_ax[p][c[0]]) + DW'(r_by[p][c[1]])
                          + DW'(r_cz[p][c[2]]) + DW'(r_d1[p]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_act2 <= r_act1;
            r_r2   <= n_r2;
            r_nr2  <= -n_r2;
            r_t    <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_act3 <= r_act2;
            for (int p = 0; p < NP; p++) begin
                for (int c = 0; c < NC; c++) begin
                    r_beh[p][c] <= r_t[p][c][DW-1];
                end
                r_pos[p]  <= r_t[p][0] > 0;
                r_sout[p] <= r_t[p][0] < r_nr2;
                r_scr[p]  <= (r_t[p][0] < r_r2) && (r_nr2 < r_t[p][0]);
            end
        end
    end

    always_comb begin
        logic out_any, all_in;
        out_any = 1'b0;
        all_in  = 1'b1;
        for (int p = 0; p < NP; p++) begin
            if (&r_beh[p]) out_any = 1'b1;
            if (|r_beh[p]) all_in  = 1'b0;
        end
        unique case (fct_pkg::t_action'(r_act3))
            fct_pkg::ACT_POINT:
                n_verdict = (&r_pos) ? fct_pkg::VERD_INSIDE : fct_pkg::VERD_OUTSIDE;
            fct_pkg::ACT_SPHERE:
                n_verdict = (|r_sout) ? fct_pkg::VERD_OUTSIDE :
                            (|r_scr)  ? fct_pkg::VERD_INTERSECT : fct_pkg::VERD_INSIDE;
            fct_pkg::ACT_BOX:
                n_verdict = out_any ? fct_pkg::VERD_OUTSIDE :
                            all_in  ? fct_pkg::VERD_INSIDE : fct_pkg::VERD_INTERSECT;
            default:
                n_verdict = fct_pkg::VERD_OUTSIDE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out.valid   = r_v4;
    assign o_out.verdict = r_verdict;

    // loads never enter the compute stages
    `FCT_ASSERT_NEXT(a_load_no_item, i_clk, i_rst_n, w_acc && i_in.action == fct_pkg::ACT_LOAD, !r_v1)
    // a stalled pipeline keeps its items
    `FCT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_v3 && !w_adv, r_v3 && r_v4)
    `FCT_ASSERT(a_verdict_code, i_clk, i_rst_n, r_v4 |-> r_verdict != 2'd3)
endmodule
